/* hw/rtl/pcc_pkg.sv */
// Shared widths, types and class codes for the polygon convexity classifier.
package pcc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int IN_TDATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int CLASS_W     = 3;
  localparam int OUT_TDATA_W = ((CLASS_W + 7) / 8) * 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  // (a - b) and (c - b) for one triple
  typedef struct packed {
    diff_t ax;
    diff_t ay;
    diff_t cx;
    diff_t cy;
  } triple_t;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_EMPTY   = 3'd0,
    CLASS_POINT   = 3'd1,
    CLASS_LINE    = 3'd2,
    CLASS_CONVEX  = 3'd3,
    CLASS_CONCAVE = 3'd4
  } shape_class_t;

  // Beat held between the front end and the sign stage
  typedef struct packed {
    triple_t     main;
    triple_t     wrap0;
    triple_t     wrap1;
    logic        chk_main;
    logic        main_ref;
    logic        chk_wrap;
    logic        last;
    logic [1:0]  count;
  } stage_t;

endpackage

/* hw/rtl/pcc_cross.sv */
// Cross product sign of one vertex triple.
module pcc_cross (
  input  pcc_pkg::triple_t t,
  output logic             neg
);
  import pcc_pkg::*;

  prod_t p_ac;
  prod_t p_bc;

  assign p_ac = PROD_W'(t.ax) * PROD_W'(t.cy);
  assign p_bc = PROD_W'(t.ay) * PROD_W'(t.cx);
  // ax*cy - ay*cx < 0
  assign neg  = p_ac < p_bc;

endmodule

/* hw/rtl/pcc_judge.sv */
// Sign stage: cross product signs, concavity tracking and the result register.
module pcc_judge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s1_valid,
  input  pcc_pkg::stage_t                   s1,
  output logic                              take,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pcc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import pcc_pkg::*;

  logic         neg_main;
  logic         neg_w0;
  logic         neg_w1;
  logic         ref_sign;
  logic         concave;
  logic         ref_eff;
  logic         concave_next;
  shape_class_t res_class;
  shape_class_t class_next;

  pcc_cross u_main  (.t(s1.main),  .neg(neg_main));
  pcc_cross u_wrap0 (.t(s1.wrap0), .neg(neg_w0));
  pcc_cross u_wrap1 (.t(s1.wrap1), .neg(neg_w1));

  // a closing beat needs the result register free
  assign take = !s1.last || !m_tvalid || m_tready;

  always_comb begin
    ref_eff      = s1.main_ref ? neg_main : ref_sign;
    concave_next = concave
                 | (s1.chk_main && !s1.main_ref && (neg_main != ref_sign))
                 | (s1.chk_wrap && ((neg_w0 != ref_eff) || (neg_w1 != ref_eff)));
    unique case (s1.count)
      2'd0:    class_next = CLASS_EMPTY;
      2'd1:    class_next = CLASS_POINT;
      2'd2:    class_next = CLASS_LINE;
      default: class_next = concave_next ? CLASS_CONCAVE : CLASS_CONVEX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_sign <= 1'b0;
      concave  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_valid && take) begin
        if (s1.last) begin
          ref_sign <= 1'b0;
          concave  <= 1'b0;
          m_tvalid <= 1'b1;
        end else begin
          ref_sign <= ref_eff;
          concave  <= concave_next;
          if (m_tready) m_tvalid <= 1'b0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && take && s1.last) res_class <= class_next;
  end

  assign m_tdata = {{(OUT_TDATA_W-CLASS_W){1'b0}}, res_class};

endmodule

/* hw/rtl/pcc_front.sv */
// Front end: vertex history and the registered differences of each triple.
module pcc_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pcc_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                             s_tuser,
  input  logic                             s_tlast,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic                             take,
  output logic                             s1_valid,
  output pcc_pkg::stage_t                  s1
);
  import pcc_pkg::*;

  vertex_t    first_v;
  vertex_t    second_v;
  vertex_t    older_v;
  vertex_t    newer_v;
  logic [1:0] count;

  vertex_t    v;
  vertex_t    first_next;
  vertex_t    second_next;
  vertex_t    older_next;
  vertex_t    newer_next;
  logic [1:0] count_next;
  stage_t     s1_next;
  logic       accept;

  function automatic diff_t sub_c(coord_t a, coord_t b);
    return {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
  endfunction

  function automatic triple_t mk_triple(vertex_t a, vertex_t b, vertex_t c);
    triple_t t;
    t.ax = sub_c(a.x, b.x);
    t.ay = sub_c(a.y, b.y);
    t.cx = sub_c(c.x, b.x);
    t.cy = sub_c(c.y, b.y);
    return t;
  endfunction

  assign s_tready = !s1_valid || take;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    v.x         = s_tdata[COORD_WIDTH-1:0];
    v.y         = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    first_next  = first_v;
    second_next = second_v;
    older_next  = older_v;
    newer_next  = newer_v;
    count_next  = count;
    if (s_tuser) begin
      if (count == 2'd0) first_next = v;
      if (count == 2'd1) second_next = v;
      older_next = newer_v;
      newer_next = v;
      if (count != 2'd3) count_next = count + 2'd1;
    end
    s1_next.main     = mk_triple(older_v, newer_v, v);
    // wrap-around triples use the history as it stands after this beat
    s1_next.wrap0    = mk_triple(older_next, newer_next, first_next);
    s1_next.wrap1    = mk_triple(newer_next, first_next, second_next);
    s1_next.chk_main = s_tuser && (count[1] == 1'b1);
    s1_next.main_ref = s_tuser && (count == 2'd2);
    s1_next.chk_wrap = s_tlast && (count_next == 2'd3);
    s1_next.last     = s_tlast;
    s1_next.count    = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= 2'd0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= s_tlast ? 2'd0 : count_next;
        s1_valid <= 1'b1;
      end else if (take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_v  <= first_next;
      second_v <= second_next;
      older_v  <= older_next;
      newer_v  <= newer_next;
      s1       <= s1_next;
    end
  end

endmodule

/* hw/rtl/polygon_convexity_classifier.sv */
// Top level of the polygon convexity classifier.
//
//  Channel  Side    Payload
//  s_*      in      tdata: vertex_x, vertex_y; tuser: present; tlast: last
//  m_*      out     tdata: shape_class (zero padded to a byte)
//
// One beat accepted per cycle while s_tready is high. A closing beat's class
// reaches m_* through the difference register, then the sign stage into the
// result register, where the two wrap-around cross products run beside the main one.
// s_tready falls only while a closing beat waits behind an untaken result.
// Reset clears the valid flags, the vertex count and the sign tracking.
module polygon_convexity_classifier (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pcc_pkg::IN_TDATA_W-1:0]   s_tdata,   // vertex_x, vertex_y
  input  logic                             s_tuser,   // present
  input  logic                             s_tlast,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  output logic [pcc_pkg::OUT_TDATA_W-1:0]  m_tdata,   // shape_class
  output logic                             m_tvalid,
  input  logic                             m_tready
);
  import pcc_pkg::*;

  logic   s1_valid;
  logic   take;
  stage_t s1;

  pcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .take     (take),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  pcc_judge u_judge (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
